/* src/adaptive_hop_channel_blacklist_core_assert.svh */
// ---------------------------------------------------------------------------
// assertion macros for the channel blacklist core
// implication checks clocked on clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_HOP_CHANNEL_BLACKLIST_CORE_ASSERT_SVH
`define ADAPTIVE_HOP_CHANNEL_BLACKLIST_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define AHCB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahcb assertion failed");

// consequent checked in the next cycle
`define AHCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahcb assertion failed");

`endif

/* src/ahcb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ahcb_pkg
// shared types, constants and the fixed hop table of the blacklist core
// ---------------------------------------------------------------------------
package ahcb_pkg;

    localparam int NUM_CHANNELS = 128;
    localparam int CH_AW        = $clog2(NUM_CHANNELS);
    localparam int TABLE_LEN    = 16;

    // request codes
    localparam logic [2:0] FUNC_REC_TX  = 3'd0;
    localparam logic [2:0] FUNC_REC_CRC = 3'd1;
    localparam logic [2:0] FUNC_UPDATE  = 3'd2;
    localparam logic [2:0] FUNC_NEXT    = 3'd3;
    localparam logic [2:0] FUNC_QUERY   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_INTERVAL = 3'd0;
    localparam logic [2:0] REG_BL_TH    = 3'd1;
    localparam logic [2:0] REG_REC_TH   = 3'd2;
    localparam logic [2:0] REG_MIN_ACT  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT  = 3'd4;

    localparam logic [6:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic [2:0]        func;
        logic [6:0]        channel;
        logic              acked;
        logic signed [7:0] rssi;
        logic [31:0]       now_ms;
    } req_t;

    typedef struct packed {
        logic [6:0]        hop_channel;
        logic [4:0]        list_len;
        logic              is_blacklisted;
        logic [6:0]        quality;
        logic signed [7:0] mean_rssi;
        logic              updated;
    } rsp_t;

    typedef struct packed {
        logic [15:0] interval;
        logic [6:0]  bl_th;
        logic [6:0]  rec_th;
        logic [4:0]  min_active;
        logic [19:0] tout;
    } cfg_t;

    // one row of per-channel statistics
    typedef struct packed {
        logic [15:0]        tx;
        logic [15:0]        ack;
        logic [15:0]        crc;
        logic signed [23:0] sum;
        logic [15:0]        cnt;
        logic [6:0]         loss;
        logic signed [7:0]  avg;
        logic               bl;
        logic [31:0]        stamp;
        logic [7:0]         rec;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    localparam row_t ROW_RESET = '{tx: 16'd0, ack: 16'd0, crc: 16'd0, sum: 24'sd0,
                                   cnt: 16'd0, loss: 7'd0, avg: -8'sd50, bl: 1'b0,
                                   stamp: 32'd0, rec: 8'd0};

    typedef struct packed {
        logic             latch;
        logic             rd;
        logic             rd_req;
        logic [CH_AW-1:0] addr;
        logic             hop_step;
        logic             out;
        logic             rec_wr;
        logic             upd_start;
        logic             loss_start;
        logic             loss_latch;
        logic             avg_start;
        logic             ch_wr;
        logic             list_clr;
        logic             list_p1;
        logic             list_p2;
        logic             list_fix;
        logic [3:0]       tidx;
    } cmd_t;

    typedef struct packed {
        logic upd_due;
        logic div_done;
        logic len_lt_min;
    } sts_t;

    function automatic logic [6:0] hop_table(input logic [3:0] idx);
        logic [6:0] c;
        unique case (idx)
            4'd0:    c = 7'd8;
            4'd1:    c = 7'd13;
            4'd2:    c = 7'd18;
            4'd3:    c = 7'd33;
            4'd4:    c = 7'd38;
            4'd5:    c = 7'd43;
            4'd6:    c = 7'd58;
            4'd7:    c = 7'd63;
            4'd8:    c = 7'd10;
            4'd9:    c = 7'd15;
            4'd10:   c = 7'd35;
            4'd11:   c = 7'd40;
            4'd12:   c = 7'd60;
            4'd13:   c = 7'd65;
            4'd14:   c = 7'd70;
            4'd15:   c = 7'd75;
            default: c = 7'd8;
        endcase
        return c;
    endfunction

endpackage

/* src/ahcb_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ahcb_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module ahcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/ahcb_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ahcb_div
// restoring divider, one quotient bit a cycle, seven bit quotient
// ---------------------------------------------------------------------------
module ahcb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [6:0]  quo
);

    logic [2:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [23:0] rem_reg;
    logic [21:0] dsh_reg;
    logic [6:0]  q_reg;
    logic        take;

    // caller guarantees the quotient fits seven bits
    assign take = rem_reg >= {2'b00, dsh_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 3'd6;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 3'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, 6'b0};
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - {2'b00, dsh_reg};
            end
            q_reg   <= {q_reg[5:0], take};
            dsh_reg <= {1'b0, dsh_reg[21:1]};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* src/ahcb_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ahcb_ctrl
// sequencer for requests, the per-channel update pass and the list rebuild
// ---------------------------------------------------------------------------
module ahcb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          func,
    input  ahcb_pkg::sts_t      sts,
    output ahcb_pkg::cmd_t      cmd,
    output logic                busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_FIN   = 4'd2;
    localparam logic [3:0] S_UCHK  = 4'd3;
    localparam logic [3:0] S_CRD   = 4'd4;
    localparam logic [3:0] S_CLOSS = 4'd5;
    localparam logic [3:0] S_CLW   = 4'd6;
    localparam logic [3:0] S_CAVG  = 4'd7;
    localparam logic [3:0] S_CAW   = 4'd8;
    localparam logic [3:0] S_CWR   = 4'd9;
    localparam logic [3:0] S_TCLR  = 4'd10;
    localparam logic [3:0] S_T1RD  = 4'd11;
    localparam logic [3:0] S_T1    = 4'd12;
    localparam logic [3:0] S_T2RD  = 4'd13;
    localparam logic [3:0] S_T2    = 4'd14;
    localparam logic [3:0] S_FIX   = 4'd15;

    localparam logic [ahcb_pkg::CH_AW-1:0] CH_LAST =
        ahcb_pkg::CH_AW'(ahcb_pkg::NUM_CHANNELS - 1);

    logic [3:0]                  state_reg, state_next;
    logic [2:0]                  func_reg, func_next;
    logic [ahcb_pkg::CH_AW-1:0]  chan_reg, chan_next;
    logic [3:0]                  tidx_reg, tidx_next;
    logic [ahcb_pkg::CH_AW-1:0]  tab_addr;

    assign tab_addr = ahcb_pkg::CH_AW'(ahcb_pkg::hop_table(tidx_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= ahcb_pkg::FUNC_QUERY;
            chan_reg  <= '0;
            tidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            chan_reg  <= chan_next;
            tidx_reg  <= tidx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        chan_next  = chan_reg;
        tidx_next  = tidx_reg;
        cmd        = '0;
        cmd.tidx   = tidx_reg;
        cmd.addr   = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    func_next = func;
                    state_next = (func == ahcb_pkg::FUNC_UPDATE) ? S_UCHK : S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd       = 1'b1;
                cmd.rd_req   = 1'b1;
                cmd.hop_step = (func_reg == ahcb_pkg::FUNC_NEXT);
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                cmd.out    = 1'b1;
                cmd.rec_wr = (func_reg == ahcb_pkg::FUNC_REC_TX) ||
                             (func_reg == ahcb_pkg::FUNC_REC_CRC);
                state_next = S_IDLE;
            end
            S_UCHK:
            begin
                if (sts.upd_due)
                begin
                    cmd.upd_start = 1'b1;
                    chan_next     = '0;
                    state_next    = S_CRD;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_CRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CLOSS;
            end
            S_CLOSS:
            begin
                cmd.loss_start = 1'b1;
                state_next     = S_CLW;
            end
            S_CLW:
            begin
                if (sts.div_done)
                begin
                    cmd.loss_latch = 1'b1;
                    state_next     = S_CAVG;
                end
            end
            S_CAVG:
            begin
                cmd.avg_start = 1'b1;
                state_next    = S_CAW;
            end
            S_CAW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                cmd.ch_wr = 1'b1;
                if (chan_reg == CH_LAST)
                begin
                    state_next = S_TCLR;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_TCLR:
            begin
                cmd.list_clr = 1'b1;
                tidx_next    = '0;
                state_next   = S_T1RD;
            end
            S_T1RD:
            begin
                cmd.rd     = 1'b1;
                cmd.addr   = tab_addr;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.list_p1 = 1'b1;
                cmd.addr    = tab_addr;
                tidx_next   = tidx_reg + 4'd1;
                state_next  = (tidx_reg == 4'd15) ? S_T2RD : S_T1RD;
            end
            S_T2RD:
            begin
                if (sts.len_lt_min)
                begin
                    cmd.rd     = 1'b1;
                    cmd.addr   = tab_addr;
                    state_next = S_T2;
                end
                else
                begin
                    state_next = S_FIX;
                end
            end
            S_T2:
            begin
                cmd.list_p2 = 1'b1;
                cmd.addr    = tab_addr;
                tidx_next   = tidx_reg + 4'd1;
                state_next  = (tidx_reg == 4'd15) ? S_FIX : S_T2RD;
            end
            S_FIX:
            begin
                cmd.list_fix = 1'b1;
                state_next   = S_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* src/ahcb_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ahcb_dp
// channel statistics store, divider, hop list and result register
// ---------------------------------------------------------------------------
module ahcb_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  ahcb_pkg::cmd_t   cmd,
    output ahcb_pkg::sts_t   sts,
    input  ahcb_pkg::req_t   request,
    input  ahcb_pkg::cfg_t   cfg,
    output logic             done,
    output ahcb_pkg::rsp_t   result
);

    localparam int AW = ahcb_pkg::CH_AW;

    ahcb_pkg::req_t               req_reg;
    logic [ahcb_pkg::NUM_CHANNELS-1:0] valid_bits_reg;
    logic                         row_valid_reg;
    logic [ahcb_pkg::ROW_W-1:0]   rd_data;
    ahcb_pkg::row_t               row;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    ahcb_pkg::row_t               wr_row;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                req_addr;
    logic                         ch_ok;

    logic [6:0]                   loss_res_reg;
    logic [31:0]                  last_update_reg;
    logic                         updated_reg;
    logic [6:0]                   list_reg [ahcb_pkg::TABLE_LEN];
    logic [4:0]                   len_reg;
    logic [3:0]                   hop_reg;
    logic                         done_reg;
    ahcb_pkg::rsp_t               result_reg;

    logic                         div_start;
    logic [23:0]                  div_dividend;
    logic [15:0]                  div_divisor;
    logic                         div_done;
    logic [6:0]                   div_quo;

    ahcb_pkg::row_t               rec_row;
    ahcb_pkg::row_t               ch_row;
    ahcb_pkg::row_t               p2_row;
    logic signed [24:0]           sum_ext;
    logic [15:0]                  lost;
    logic                         neg;
    logic [23:0]                  mag;
    logic                         ovf;
    logic [6:0]                   loss_new;
    logic signed [7:0]            avg_new;
    logic [23:0]                  sum_rnd;
    logic                         p2_take;
    logic [6:0]                   tab_ch;
    ahcb_pkg::rsp_t               rsp_new;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    assign req_addr = AW'(req_reg.channel);
    assign ch_ok    = ((AW + 1)'(req_reg.channel) < (AW + 1)'(ahcb_pkg::NUM_CHANNELS));
    assign rd_addr  = cmd.rd_req ? req_addr : cmd.addr;
    assign row      = row_valid_reg ? ahcb_pkg::row_t'(rd_data) : ahcb_pkg::ROW_RESET;
    assign tab_ch   = ahcb_pkg::hop_table(cmd.tidx);

    ahcb_ram #(
        .WIDTH(ahcb_pkg::ROW_W),
        .DEPTH(ahcb_pkg::NUM_CHANNELS)
    ) u_stats (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_row),
        .rd_en  (cmd.rd),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // divider operands: loss percent, then magnitude of the rssi average
    assign lost         = (row.tx > row.ack) ? row.tx - row.ack : 16'd0;
    assign neg          = row.sum[23];
    assign mag          = neg ? 24'(-row.sum) : row.sum;
    assign ovf          = mag >= {1'b0, row.cnt, 7'b0};
    assign div_start    = cmd.loss_start | cmd.avg_start;
    assign div_dividend = cmd.loss_start ? 24'(lost) * 24'd100 : mag;
    assign div_divisor  = cmd.loss_start ? row.tx : row.cnt;

    ahcb_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quo     (div_quo)
    );

    // record update
    always_comb
    begin
        rec_row = row;
        sum_ext = 25'(row.sum) + 25'(req_reg.rssi);
        if (req_reg.func == ahcb_pkg::FUNC_REC_TX)
        begin
            rec_row.tx = sat_inc16(row.tx);
            if (req_reg.acked)
            begin
                rec_row.ack = sat_inc16(row.ack);
            end
            if (sum_ext > 25'sd8388607)
            begin
                rec_row.sum = 24'sh7FFFFF;
            end
            else if (sum_ext < -25'sd8388608)
            begin
                rec_row.sum = 24'sh800000;
            end
            else
            begin
                rec_row.sum = sum_ext[23:0];
            end
            rec_row.cnt = sat_inc16(row.cnt);
        end
        else
        begin
            rec_row.crc = sat_inc16(row.crc);
        end
    end

    // per-channel quality update
    always_comb
    begin
        loss_new = (row.tx == 16'd0) ? row.loss : loss_res_reg;
        if (row.cnt == 16'd0)
        begin
            avg_new = row.avg;
        end
        else if (ovf)
        begin
            avg_new = neg ? -8'sd128 : 8'sd127;
        end
        else
        begin
            avg_new = neg ? 8'(8'd0 - {1'b0, div_quo}) : 8'({1'b0, div_quo});
        end
        ch_row      = row;
        ch_row.loss = loss_new;
        ch_row.avg  = avg_new;
        if (!row.bl && (loss_new > cfg.bl_th) && (len_reg > cfg.min_active))
        begin
            ch_row.bl    = 1'b1;
            ch_row.stamp = req_reg.now_ms;
            ch_row.rec   = 8'd0;
        end
        if (ch_row.bl && ((req_reg.now_ms - ch_row.stamp) > {12'd0, cfg.tout}))
        begin
            if (loss_new < cfg.rec_th)
            begin
                ch_row.bl = 1'b0;
            end
            else
            begin
                ch_row.stamp = req_reg.now_ms;
                if (ch_row.rec != 8'hFF)
                begin
                    ch_row.rec = ch_row.rec + 8'd1;
                end
            end
        end
        // halve, sum truncates toward zero
        sum_rnd    = row.sum + 24'(row.sum[23]);
        ch_row.tx  = {1'b0, row.tx[15:1]};
        ch_row.ack = {1'b0, row.ack[15:1]};
        ch_row.crc = {1'b0, row.crc[15:1]};
        ch_row.sum = {sum_rnd[23], sum_rnd[23:1]};
        ch_row.cnt = {1'b0, row.cnt[15:1]};
    end

    assign p2_take = row.bl && (len_reg < cfg.min_active);

    always_comb
    begin
        p2_row    = row;
        p2_row.bl = 1'b0;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.addr;
        wr_row  = ch_row;
        if (cmd.rec_wr && ch_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = req_addr;
            wr_row  = rec_row;
        end
        else if (cmd.ch_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.list_p2 && p2_take)
        begin
            wr_en  = 1'b1;
            wr_row = p2_row;
        end
    end

    // result fields
    always_comb
    begin
        rsp_new.hop_channel  = ((len_reg != 5'd0) && ({1'b0, hop_reg} < len_reg)) ?
                               list_reg[hop_reg] : ahcb_pkg::hop_table(4'd0);
        rsp_new.list_len     = len_reg;
        rsp_new.updated      = updated_reg;
        if (ch_ok)
        begin
            rsp_new.is_blacklisted = row.bl;
            rsp_new.quality        = ahcb_pkg::PCT_FULL - row.loss;
            rsp_new.mean_rssi      = row.avg;
        end
        else
        begin
            rsp_new.is_blacklisted = 1'b0;
            rsp_new.quality        = 7'd0;
            rsp_new.mean_rssi      = 8'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg  <= '0;
            row_valid_reg   <= 1'b0;
            last_update_reg <= '0;
            updated_reg     <= 1'b0;
            len_reg         <= 5'd16;
            hop_reg         <= '0;
            done_reg        <= 1'b0;
            for (int i = 0; i < ahcb_pkg::TABLE_LEN; i++)
            begin
                list_reg[i] <= ahcb_pkg::hop_table(4'(i));
            end
        end
        else
        begin
            done_reg <= cmd.out;
            if (cmd.rd)
            begin
                row_valid_reg <= valid_bits_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_bits_reg[wr_addr] <= 1'b1;
            end
            if (cmd.latch)
            begin
                updated_reg <= 1'b0;
            end
            if (cmd.upd_start)
            begin
                updated_reg     <= 1'b1;
                last_update_reg <= req_reg.now_ms;
            end
            if (cmd.hop_step && (len_reg != 5'd0))
            begin
                hop_reg <= (({1'b0, hop_reg} + 5'd1) >= len_reg) ? 4'd0 : hop_reg + 4'd1;
            end
            if (cmd.list_clr)
            begin
                len_reg <= '0;
            end
            if ((cmd.list_p1 && !row.bl) || (cmd.list_p2 && p2_take))
            begin
                list_reg[len_reg[3:0]] <= tab_ch;
                len_reg                <= len_reg + 5'd1;
            end
            if (cmd.list_fix && ({1'b0, hop_reg} >= len_reg))
            begin
                hop_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= request;
        end
        if (cmd.loss_latch)
        begin
            loss_res_reg <= div_quo;
        end
        if (cmd.out)
        begin
            result_reg <= rsp_new;
        end
    end

    assign sts.upd_due    = (req_reg.now_ms - last_update_reg) >= {16'd0, cfg.interval};
    assign sts.div_done   = div_done;
    assign sts.len_lt_min = len_reg < cfg.min_active;

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/adaptive_hop_channel_blacklist_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adaptive hop channel blacklist core
// per-channel link statistics, periodic blacklisting and an adaptive hop list
// ---------------------------------------------------------------------------
// a request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, and the receiver cannot
// stall it, so it must take the result in that cycle. record, query and
// next-hop requests pass a read and a finish state before done; an update
// whose interval has not passed first adds a check state. an update that
// runs walks all 128 channels through one shared 7-step divider (loss
// percent, then rssi average), then rebuilds the hop list from the 16-entry
// table, a read and a list state per entry per sweep. the statistics live
// in one ram row per channel; a per-row valid bit makes unwritten rows read
// as their reset value, so no clearing pass is needed. configuration goes
// through the apb port, by the user only while busy is low (not enforced).
// ---------------------------------------------------------------------------
module adaptive_hop_channel_blacklist_core (
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             start,
    output logic             busy,
    input  ahcb_pkg::req_t   request,
    // result channel
    output logic             done,
    output ahcb_pkg::rsp_t   result,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ahcb_pkg::cfg_t cfg_reg;
    ahcb_pkg::cmd_t cmd;
    ahcb_pkg::sts_t sts;
    logic           cfg_wr;
    logic [2:0]     reg_idx;

    // register file, word addressed
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval   <= 16'd1000;
            cfg_reg.bl_th      <= 7'd30;
            cfg_reg.rec_th     <= 7'd10;
            cfg_reg.min_active <= 5'd3;
            cfg_reg.tout       <= 20'd30000;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ahcb_pkg::REG_INTERVAL: cfg_reg.interval   <= pwdata[15:0];
                ahcb_pkg::REG_BL_TH:    cfg_reg.bl_th      <= pwdata[6:0];
                ahcb_pkg::REG_REC_TH:   cfg_reg.rec_th     <= pwdata[6:0];
                ahcb_pkg::REG_MIN_ACT:  cfg_reg.min_active <= pwdata[4:0];
                ahcb_pkg::REG_TIMEOUT:  cfg_reg.tout       <= pwdata[19:0];
                default:
                begin
                    // addresses past the register list are ignored
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ahcb_pkg::REG_INTERVAL: prdata = {16'd0, cfg_reg.interval};
            ahcb_pkg::REG_BL_TH:    prdata = {25'd0, cfg_reg.bl_th};
            ahcb_pkg::REG_REC_TH:   prdata = {25'd0, cfg_reg.rec_th};
            ahcb_pkg::REG_MIN_ACT:  prdata = {27'd0, cfg_reg.min_active};
            ahcb_pkg::REG_TIMEOUT:  prdata = {12'd0, cfg_reg.tout};
            default:                prdata = 32'd0;
        endcase
    end

    // sequencer: walks requests, the channel pass and the list rebuild
    ahcb_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .func (request.func),
        .sts  (sts),
        .cmd  (cmd),
        .busy (busy)
    );

    // datapath: statistics ram, divider, hop list, result register
    ahcb_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .request(request),
        .cfg    (cfg_reg),
        .done   (done),
        .result (result)
    );

`include "adaptive_hop_channel_blacklist_core_assert.svh"

    // an accepted request always makes the block busy next cycle
    `AHCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a result is only ever shown for one cycle at a time
    `AHCB_ASSERT_NEXT(a_done_single, done, !done)
    // a result strobe closes work that was in flight
    `AHCB_ASSERT_SAME(a_done_after_busy, done, $past(busy))
    // the hop list never holds more than the table
    `AHCB_ASSERT_SAME(a_count_range, done, result.list_len <= 5'd16)

endmodule
